>>> sv/cea861_vic_filter_macros.svh
// ----------------------------------------------------------------------------
// cea861 vic filter assertion macros
// shared concurrent assertion forms for the filter rtl
// ----------------------------------------------------------------------------
`ifndef CEA861_VIC_FILTER_MACROS_SVH
`define CEA861_VIC_FILTER_MACROS_SVH

// same-cycle implication, held off during reset
`define CVF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define CVF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg
// types and constants shared by the cea861 vic filter modules
// ----------------------------------------------------------------------------
`default_nettype none

package cvf_pkg;

   localparam int MaskWidth = 64;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_MASK_LOW  = 2'd0;
   localparam csr_index_type CSR_MASK_HIGH = 2'd1;

   localparam logic [7:0] CEA_EXT_TAG      = 8'h02;
   localparam logic [2:0] DB_TAG_VIDEO     = 3'd2;
   localparam logic [7:0] FIRST_HEADER_POS = 8'd4;
   localparam logic [7:0] MIN_DTD_OFFSET   = 8'd5;
   localparam logic [7:0] MAX_DTD_OFFSET   = 8'd127;
   localparam logic [6:0] TAG_POS          = 7'd0;
   localparam logic [6:0] DTD_OFFSET_POS   = 7'd2;
   localparam logic [6:0] WALK_START_POS   = 7'd4;
   localparam logic [6:0] LAST_POS         = 7'd127;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       vdb_found;
      logic       block_modified;
   } result_type;

endpackage

`default_nettype wire

>>> sv/cvf_csr.sv
// ----------------------------------------------------------------------------
// cvf_csr
// disabled vic mask registers and the per-byte lookup into them
// ----------------------------------------------------------------------------
`default_nettype none

module cvf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire cvf_pkg::csr_index_type          csr_index,
   input  wire logic [cvf_pkg::MaskWidth-1:0]   csr_wdata,
   input  wire logic [7:0]                      vic_byte,
   output logic                                 vic_disabled
);

   logic [cvf_pkg::MaskWidth-1:0] mask_low_ff, mask_low_in;
   logic [cvf_pkg::MaskWidth-1:0] mask_high_ff, mask_high_in;
   logic [2*cvf_pkg::MaskWidth-1:0] mask_all;
   logic [6:0] vic;

   always_comb begin
      mask_low_in  = mask_low_ff;
      mask_high_in = mask_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cvf_pkg::CSR_MASK_LOW:  mask_low_in  = csr_wdata;
            cvf_pkg::CSR_MASK_HIGH: mask_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_low_ff  <= '0;
         mask_high_ff <= '0;
      end else begin
         mask_low_ff  <= mask_low_in;
         mask_high_ff <= mask_high_in;
      end
   end

   // native bit ignored, vic 0 never disabled
   assign vic          = vic_byte[6:0];
   assign mask_all     = {mask_high_ff, mask_low_ff};
   assign vic_disabled = (vic != 7'd0) && mask_all[vic];

endmodule

`default_nettype wire

>>> sv/cvf_core.sv
// ----------------------------------------------------------------------------
// cvf_core
// per-block walk state and the edit of one byte
// ----------------------------------------------------------------------------
`default_nettype none

module cvf_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         in_byte,
   input  wire logic               vic_disabled,
   output cvf_pkg::result_type     result
);

   logic [6:0] pos_ff, pos_in;
   logic       tag_ff, tag_in;
   logic [7:0] limit_ff, limit_in;
   logic [7:0] next_hdr_ff, next_hdr_in;
   logic [4:0] left_ff, left_in;
   logic       stopped_ff, stopped_in;
   logic       found_ff, found_in;
   logic       changed_ff, changed_in;
   logic [7:0] sum_ff, sum_in;

   logic [7:0] pos_wide;
   logic [7:0] hdr_end;
   logic [7:0] o;
   logic       active;

   assign pos_wide = {1'b0, pos_ff};
   assign hdr_end  = pos_wide + {3'b000, in_byte[4:0]} + 8'd1;

   always_comb begin
      pos_in      = pos_ff;
      tag_in      = (pos_ff == cvf_pkg::TAG_POS) ? (in_byte == cvf_pkg::CEA_EXT_TAG) : tag_ff;
      limit_in    = (pos_ff == cvf_pkg::DTD_OFFSET_POS) ? in_byte : limit_ff;
      next_hdr_in = next_hdr_ff;
      left_in     = left_ff;
      stopped_in  = stopped_ff;
      found_in    = found_ff;
      changed_in  = changed_ff;
      sum_in      = sum_ff;
      o           = in_byte;
      result      = '0;

      active = tag_in && (limit_in >= cvf_pkg::MIN_DTD_OFFSET)
               && (limit_in <= cvf_pkg::MAX_DTD_OFFSET);

      if (active && (pos_ff >= cvf_pkg::WALK_START_POS)) begin
         if (left_ff != 5'd0) begin
            left_in = left_ff - 5'd1;
            if (vic_disabled) begin
               o          = 8'h00;
               changed_in = 1'b1;
            end
         end else if (!stopped_ff && (pos_wide == next_hdr_ff) && (pos_wide < limit_in)) begin
            if (in_byte[7:5] == cvf_pkg::DB_TAG_VIDEO) begin
               found_in   = 1'b1;
               left_in    = in_byte[4:0];
               stopped_in = 1'b1;
            end else begin
               next_hdr_in = hdr_end;
               if (hdr_end >= limit_in) begin
                  stopped_in = 1'b1;
               end
            end
         end
      end

      if (pos_ff == cvf_pkg::LAST_POS) begin
         result.out_byte       = changed_in ? (8'h00 - sum_ff) : o;
         result.last_byte      = 1'b1;
         result.vdb_found      = found_in;
         result.block_modified = changed_in;
         pos_in      = '0;
         tag_in      = 1'b0;
         limit_in    = '0;
         next_hdr_in = cvf_pkg::FIRST_HEADER_POS;
         left_in     = '0;
         stopped_in  = 1'b0;
         found_in    = 1'b0;
         changed_in  = 1'b0;
         sum_in      = '0;
      end else begin
         result.out_byte = o;
         sum_in          = sum_ff + o;
         pos_in          = pos_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         tag_ff      <= 1'b0;
         limit_ff    <= '0;
         next_hdr_ff <= cvf_pkg::FIRST_HEADER_POS;
         left_ff     <= '0;
         stopped_ff  <= 1'b0;
         found_ff    <= 1'b0;
         changed_ff  <= 1'b0;
         sum_ff      <= '0;
      end else if (step) begin
         pos_ff      <= pos_in;
         tag_ff      <= tag_in;
         limit_ff    <= limit_in;
         next_hdr_ff <= next_hdr_in;
         left_ff     <= left_in;
         stopped_ff  <= stopped_in;
         found_ff    <= found_in;
         changed_ff  <= changed_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/cea861_vic_filter.sv
// ----------------------------------------------------------------------------
// cea861_vic_filter
// streaming vic filter for one 128-byte cea-861 edid extension block
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   req      | in        | req_valid/req_ready  | req_in_byte
//   rsp      | out       | rsp_valid/rsp_ready  | rsp_out_byte, rsp_last_byte,
//            |           |                      | rsp_vdb_found, rsp_block_modified
//   csr      | in        | csr_wr_en            | csr_index, csr_wdata
//
// one item per cycle unless the rsp side stalls; each item passes through the
// input register and leaves from the result register
// the edit of a byte is one pass from the input register to the result register
// synchronous active-high reset clears the masks and the block walk state
// a stalled result register holds; the input register still takes an item
// while the result waits, so the req side stalls only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

`include "cea861_vic_filter_macros.svh"

module cea861_vic_filter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // byte input
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_in_byte,
   // filtered byte output
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_last_byte,
   output logic                                 rsp_vdb_found,
   output logic                                 rsp_block_modified,
   // mask registers
   input  wire logic                            csr_wr_en,
   input  wire cvf_pkg::csr_index_type          csr_index,
   input  wire logic [cvf_pkg::MaskWidth-1:0]   csr_wdata
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   cvf_pkg::result_type out_result_ff, out_result_in;

   cvf_pkg::result_type core_result;
   logic                vic_disabled;
   logic                advance;
   logic                req_take;

   // the byte in the input register moves on when the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_result_in = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      // payload registers, no reset
      in_byte_ff    <= in_byte_in;
      out_result_ff <= out_result_in;
   end

   // mask registers and the vic lookup on the held byte
   cvf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .vic_byte     (in_byte_ff),
      .vic_disabled (vic_disabled)
   );

   // block walk, state steps once per byte handed on
   cvf_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .in_byte      (in_byte_ff),
      .vic_disabled (vic_disabled),
      .result       (core_result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_result_ff.out_byte;
   assign rsp_last_byte      = out_result_ff.last_byte;
   assign rsp_vdb_found      = out_result_ff.vdb_found;
   assign rsp_block_modified = out_result_ff.block_modified;

   // block flags only ride on the last byte
   `CVF_ASSERT_IMP(a_flags_on_last, clock, reset, rsp_valid && !rsp_last_byte, !rsp_vdb_found && !rsp_block_modified, "block flags set on a byte other than the last")

   // a cleared vic can only come from a video data block
   `CVF_ASSERT_IMP(a_modified_needs_vdb, clock, reset, rsp_valid && rsp_block_modified, rsp_vdb_found, "block modified without a video data block")

   // a held input byte stays put until the result slot frees
   `CVF_ASSERT_NXT(a_input_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "input register lost or changed a waiting byte")

   // a stalled result is not overwritten by the core
   `CVF_ASSERT_NXT(a_result_holds, clock, reset, out_valid_ff && !rsp_ready, out_valid_ff && $stable(out_result_ff), "result register changed while stalled")

endmodule

`default_nettype wire

>>> test/cea861_vic_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cea861_vic_filter_checker
// watches the byte and result channels of the vic filter, keeps its own
// model of the block walk and the disabled-vic masks, and compares every
// filtered byte that leaves the block with the byte it should have been
// ----------------------------------------------------------------------------
module cea861_vic_filter_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [7:0]                          req_in_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [7:0]                          rsp_out_byte,
   input  logic                                rsp_last_byte,
   input  logic                                rsp_vdb_found,
   input  logic                                rsp_block_modified,
   input  logic                                csr_wr_en,
   input  cvf_pkg::csr_index_type              csr_index,
   input  logic [cvf_pkg::MaskWidth-1:0]       csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  bytes_checked,
   output int                                  blocks_checked,
   output int                                  vdb_blocks,
   output int                                  edited_blocks
);
   import cvf_pkg::*;

   localparam int ReportLimit = 10;

   logic [MaskWidth-1:0] mask_low;
   logic [MaskWidth-1:0] mask_high;

   // per-block walk state
   logic [6:0] byte_pos;
   logic       cea_tag;
   logic [7:0] dtd_offset;
   logic [7:0] next_header;
   logic [4:0] vdb_left;
   logic       walk_done;
   logic       vdb_seen;
   logic       edited;
   logic [7:0] byte_sum;

   result_type filtered_bytes[$];

   function automatic void clear_walk();
      byte_pos    = '0;
      cea_tag     = 1'b0;
      dtd_offset  = '0;
      next_header = FIRST_HEADER_POS;
      vdb_left    = '0;
      walk_done   = 1'b0;
      vdb_seen    = 1'b0;
      edited      = 1'b0;
      byte_sum    = '0;
   endfunction

   // vic 0 is never looked up, bit 7 (native) is ignored
   function automatic logic vic_disabled(input logic [7:0] svd);
      logic [6:0] vic;
      vic = svd[6:0];
      if (vic == 7'd0)
         return 1'b0;
      if (vic < 7'd64)
         return mask_low[vic[5:0]];
      return mask_high[vic[5:0]];
   endfunction

   function automatic result_type filter_byte(input logic [7:0] in_byte);
      result_type res;
      logic       editing;
      res          = '0;
      res.out_byte = in_byte;
      if (byte_pos == TAG_POS)
         cea_tag = (in_byte == CEA_EXT_TAG);
      if (byte_pos == DTD_OFFSET_POS)
         dtd_offset = in_byte;
      editing = cea_tag && dtd_offset >= MIN_DTD_OFFSET && dtd_offset <= MAX_DTD_OFFSET;
      if (editing && byte_pos >= WALK_START_POS) begin
         if (vdb_left != 5'd0) begin
            vdb_left = vdb_left - 5'd1;
            if (vic_disabled(in_byte)) begin
               res.out_byte = 8'h00;
               edited       = 1'b1;
            end
         end else if (!walk_done && {1'b0, byte_pos} == next_header &&
                      {1'b0, byte_pos} < dtd_offset) begin
            if (in_byte[7:5] == DB_TAG_VIDEO) begin
               vdb_seen  = 1'b1;
               vdb_left  = in_byte[4:0];
               walk_done = 1'b1;
            end else begin
               next_header = {1'b0, byte_pos} + {3'd0, in_byte[4:0]} + 8'd1;
               if (next_header >= dtd_offset)
                  walk_done = 1'b1;
            end
         end
      end
      if (byte_pos == LAST_POS) begin
         if (edited)
            res.out_byte = 8'h00 - byte_sum;
         res.last_byte      = 1'b1;
         res.vdb_found      = vdb_seen;
         res.block_modified = edited;
         clear_walk();
      end else begin
         byte_sum = byte_sum + res.out_byte;
         byte_pos = byte_pos + 7'd1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         mask_low  = '0;
         mask_high = '0;
         clear_walk();
         filtered_bytes.delete();
         fail_count     = 0;
         bytes_checked  = 0;
         blocks_checked = 0;
         vdb_blocks     = 0;
         edited_blocks  = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MASK_LOW:  mask_low  = csr_wdata;
               CSR_MASK_HIGH: mask_high = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            filtered_bytes.push_back(filter_byte(req_in_byte));
         if (rsp_valid && rsp_ready) begin
            if (filtered_bytes.size() == 0) begin
               fail_count++;
               if (fail_count <= ReportLimit)
                  $display("[%0t] unexpected item: byte %02h last %0b vdb %0b mod %0b",
                           $realtime, rsp_out_byte, rsp_last_byte, rsp_vdb_found,
                           rsp_block_modified);
            end else begin
               want = filtered_bytes.pop_front();
               bytes_checked++;
               if (want.last_byte) begin
                  blocks_checked++;
                  if (want.vdb_found)      vdb_blocks++;
                  if (want.block_modified) edited_blocks++;
               end
               if (rsp_out_byte != want.out_byte || rsp_last_byte != want.last_byte ||
                   rsp_vdb_found != want.vdb_found ||
                   rsp_block_modified != want.block_modified) begin
                  fail_count++;
                  if (fail_count <= ReportLimit)
                     $display("[%0t] mismatch: exp byte %02h last %0b vdb %0b mod %0b, got byte %02h last %0b vdb %0b mod %0b",
                              $realtime, want.out_byte, want.last_byte, want.vdb_found,
                              want.block_modified, rsp_out_byte, rsp_last_byte,
                              rsp_vdb_found, rsp_block_modified);
               end
            end
         end
      end
      pending_count <= filtered_bytes.size();
   end

endmodule

>>> test/cea861_vic_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cea861_vic_filter_tb
// streams edid extension blocks through the vic filter: a hand-built walk
// block, random blocks of two shapes and a hand-built overrun block,
// under four idling phases and four mask settings; the checker beside
// the block does the scoring
// ----------------------------------------------------------------------------
module cea861_vic_filter_tb;
   import cvf_pkg::*;

   localparam int ClockPeriod = 4;
   localparam int ResetCycles = 5;
   localparam int CycleLimit  = 200000;
   localparam int BlockBytes  = 128;
   localparam int DrainCycles = 6;
   localparam int NumPhases   = 4;

   // index 3 is not a register, writes to it must be dropped
   localparam csr_index_type CSR_SPARE = 2'd3;

   typedef enum int {
      SHAPE_WALK,
      SHAPE_LATE_VDB,
      SHAPE_BAD_TAG,
      SHAPE_BAD_OFFSET
   } block_shape_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_in_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last_byte;
   logic                 rsp_vdb_found;
   logic                 rsp_block_modified;
   logic                 csr_wr_en = 1'b0;
   csr_index_type        csr_index = CSR_MASK_LOW;
   logic [MaskWidth-1:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int bytes_checked;
   int blocks_checked;
   int vdb_blocks;
   int edited_blocks;

   int cycle_count   = 0;
   int send_idle_pct = 0;   // chance in a hundred that the sender skips a cycle
   int stall_pct     = 0;   // chance in a hundred that the receiver stalls

   logic [7:0] block_bytes [BlockBytes];

   // random block count for each phase and the shape of each random block in turn, content is random
   int              blocks_per_phase [NumPhases] = '{0, 1, 1, 0};
   block_shape_type shape_plan [2] = '{SHAPE_BAD_OFFSET, SHAPE_WALK};

   cea861_vic_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_vdb_found      (rsp_vdb_found),
      .rsp_block_modified (rsp_block_modified),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   cea861_vic_filter_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_vdb_found      (rsp_vdb_found),
      .rsp_block_modified (rsp_block_modified),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .bytes_checked      (bytes_checked),
      .blocks_checked     (blocks_checked),
      .vdb_blocks         (vdb_blocks),
      .edited_blocks      (edited_blocks)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one register write per cycle; the caller drops the enable afterwards
   task automatic write_csr(input csr_index_type idx, input logic [MaskWidth-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // valid is left high after the item goes in, so back-to-back items never
   // see valid dropped and raised in the same step; idle cycles lower it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_block();
      for (int i = 0; i < BlockBytes; i++)
         send_byte(block_bytes[i]);
   endtask

   // stop sending and let every outstanding item come back, plus the pipeline
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // random block: a header chain from byte 4 with random payloads
   task automatic build_random_block(input block_shape_type shape);
      int         pos;
      int         len;
      logic [2:0] tag;
      for (int i = 0; i < BlockBytes; i++)
         block_bytes[i] = 8'($urandom_range(0, 255));
      block_bytes[0] = CEA_EXT_TAG;
      // now and then the smallest dtd offset, so only the first header counts
      block_bytes[2] = ($urandom_range(0, 7) == 0) ? MIN_DTD_OFFSET
                                                   : 8'($urandom_range(5, 127));
      case (shape)
         SHAPE_BAD_TAG: begin
            while (block_bytes[0] == CEA_EXT_TAG)
               block_bytes[0] = 8'($urandom_range(0, 255));
         end
         SHAPE_BAD_OFFSET: begin
            block_bytes[2] = $urandom_range(0, 1) ? 8'($urandom_range(0, 4))
                                                  : 8'($urandom_range(128, 255));
         end
         SHAPE_LATE_VDB: begin
            block_bytes[2] = MAX_DTD_OFFSET;
         end
         default: ;
      endcase
      pos = int'(WALK_START_POS);
      while (pos < BlockBytes) begin
         len = int'($urandom_range(0, 31));
         tag = 3'($urandom_range(0, 7));
         if (shape == SHAPE_LATE_VDB) begin
            // other data blocks first, then a video block that runs off the end
            if (pos < 100) begin
               len = int'($urandom_range(0, 15));
               if (tag == DB_TAG_VIDEO)
                  tag = 3'd3;
            end else begin
               tag = DB_TAG_VIDEO;
               len = 31;
            end
         end else if ($urandom_range(0, 2) == 0) begin
            tag = DB_TAG_VIDEO;
         end
         block_bytes[pos] = {tag, len[4:0]};
         pos += len + 1;
      end
   endtask

   // walk over audio and empty speaker blocks into a video block with the
   // vic extremes, then a second video block that must be left alone
   task automatic build_walk_block();
      for (int i = 0; i < BlockBytes; i++)
         block_bytes[i] = i[7:0];
      block_bytes[0]  = CEA_EXT_TAG;
      block_bytes[1]  = 8'h03;
      block_bytes[2]  = MAX_DTD_OFFSET;
      block_bytes[3]  = 8'hf0;
      block_bytes[4]  = {3'd1, 5'd3};
      block_bytes[5]  = 8'h09;
      block_bytes[6]  = 8'h7f;
      block_bytes[7]  = 8'h07;
      block_bytes[8]  = {3'd4, 5'd0};
      block_bytes[9]  = {DB_TAG_VIDEO, 5'd8};
      block_bytes[10] = 8'h00;   // vic zero
      block_bytes[11] = 8'h80;   // vic zero with native bit
      block_bytes[12] = 8'h01;
      block_bytes[13] = 8'h81;   // native bit ignored for the lookup
      block_bytes[14] = 8'h3f;   // top of the low mask
      block_bytes[15] = 8'h40;   // bottom of the high mask
      block_bytes[16] = 8'h7f;
      block_bytes[17] = 8'hff;
      block_bytes[18] = {DB_TAG_VIDEO, 5'd2};
      block_bytes[19] = 8'h01;
      block_bytes[20] = 8'h10;
      block_bytes[21] = {3'd7, 5'd31};
   endtask

   // long data blocks push the video block to byte 121, so its descriptors
   // reach byte 127; the last one is a high-mask vic that marks the block modified, but goes out as the checksum
   task automatic build_overrun_block();
      for (int i = 0; i < BlockBytes; i++)
         block_bytes[i] = i[7:0] ^ 8'h5a;
      block_bytes[0]   = CEA_EXT_TAG;
      block_bytes[2]   = MAX_DTD_OFFSET;
      block_bytes[4]   = {3'd3, 5'd31};
      block_bytes[36]  = {3'd1, 5'd31};
      block_bytes[68]  = {3'd4, 5'd31};
      block_bytes[100] = {3'd5, 5'd20};
      block_bytes[121] = {DB_TAG_VIDEO, 5'd31};
      block_bytes[127] = 8'hc5;
   endtask

   initial begin
      int shape_idx;
      shape_idx = 0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < NumPhases; phase++) begin
         if (phase > 0)
            drain();

         // idling mix: none, sender gaps, receiver stalls, both lightly
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 75; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase

         // mask settings: all disabled, none disabled, random, sparse low / full high
         case (phase)
            0: begin
               write_csr(CSR_MASK_LOW, '1);
               write_csr(CSR_MASK_HIGH, '1);
               write_csr(CSR_SPARE, {$urandom, $urandom});
            end
            1: begin
               write_csr(CSR_MASK_LOW, '0);
               write_csr(CSR_MASK_HIGH, '0);
            end
            2: begin
               write_csr(CSR_MASK_LOW, {$urandom, $urandom});
               write_csr(CSR_MASK_HIGH, {$urandom, $urandom});
            end
            default: begin
               write_csr(CSR_MASK_LOW, {$urandom, $urandom} & {$urandom, $urandom});
               write_csr(CSR_MASK_HIGH, '1);
            end
         endcase
         csr_wr_en <= 1'b0;

         if (phase == 0) begin
            build_walk_block();
            send_block();
         end

         for (int k = 0; k < blocks_per_phase[phase]; k++) begin
            build_random_block(shape_plan[shape_idx]);
            send_block();
            shape_idx++;
         end

         if (phase == NumPhases - 1) begin
            build_overrun_block();
            send_block();
         end
      end

      drain();

      $display("summary: %0d bytes in %0d blocks checked over 4 idling phases",
               bytes_checked, blocks_checked);
      $display("summary: 4 mask settings, %0d blocks held a video data block, %0d were edited",
               vdb_blocks, edited_blocks);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> cea861_vic_filter.f
+incdir+sv
sv/cvf_pkg.sv
sv/cvf_csr.sv
sv/cvf_core.sv
sv/cea861_vic_filter.sv
test/cea861_vic_filter_checker.sv
test/cea861_vic_filter_tb.sv
